>>> rtl/scrambled_sobol_point_generator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scrambled Sobol point generator
// Shared property templates, clocked and reset-disabled.
// ----------------------------------------------------------------------------
`ifndef SCRAMBLED_SOBOL_POINT_GENERATOR_CORE_DEFINES_SVH
`define SCRAMBLED_SOBOL_POINT_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define SSOBOL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SSOBOL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ssobol_pkg.sv
// ----------------------------------------------------------------------------
// Scrambled Sobol generator package
// Field widths, codes, scrambling constants and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ssobol_pkg;

	localparam int WORD_W    = 32;
	localparam int TABLE_LEN = 32;
	localparam int TBL_AW    = 5;
	localparam int DEG_W     = 5;
	localparam int POLY_W    = 17;
	localparam int IDX_W     = 5;
	localparam int INIT_W    = 18;
	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int APB_W     = 32;
	localparam int PADDR_W   = 3;
	localparam int SCR_BITS  = 31;
	localparam int PROD_W    = 2 * SCR_BITS;

	localparam logic [SCR_BITS-1:0] SCR_MODULUS    = 31'd2147483647;
	localparam logic [SCR_BITS-1:0] SCR_MULTIPLIER = 31'd1583458089;

	localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NEXT    = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;

	localparam logic REG_DEGREE = 1'b0;
	localparam logic REG_POLY   = 1'b1;

	typedef struct packed {
		logic [DEG_W-1:0]  degree;
		logic [POLY_W-1:0] poly_coeffs;
	} ssobol_cfg_t;

	typedef struct packed {
		logic              build_start;
		logic              load_we;
		logic [IDX_W-1:0]  load_addr;
		logic [INIT_W-1:0] load_data;
		logic              rd_en;
		logic [TBL_AW-1:0] rd_addr;
	} ssobol_tbl_req_t;

	typedef struct packed {
		logic              busy;
		logic [WORD_W-1:0] rd_data;
	} ssobol_tbl_sts_t;

	typedef struct packed {
		logic                valid;
		logic [WORD_W-1:0]   raw;
		logic [WORD_W-1:0]   number;
		logic [STATUS_W-1:0] status;
	} ssobol_push_t;

endpackage

`default_nettype wire

>>> rtl/ssobol_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying load, restart and next requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssobol_in_if import ssobol_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [IDX_W-1:0]  init_index;
	logic [INIT_W-1:0] init_value;

	modport source (output valid, output mode, output init_index, output init_value,
		input ready);
	modport sink (input valid, input mode, input init_index, input init_value,
		output ready);
endinterface

`default_nettype wire

>>> rtl/ssobol_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying scrambled points and their status.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssobol_out_if import ssobol_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   point_value;
	logic [WORD_W-1:0]   point_number;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output point_value, output point_number, output status,
		input ready);
	modport sink (input valid, input point_value, input point_number, input status,
		output ready);
endinterface

`default_nettype wire

>>> rtl/ssobol_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the polynomial degree and coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module ssobol_regs import ssobol_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire  [PADDR_W-1:0] paddr,
	input  wire  [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready,
	output ssobol_cfg_t        cfg
);

	logic [DEG_W-1:0]  degree_q;
	logic [POLY_W-1:0] poly_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// byte lanes below the word address are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			poly_q   <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_DEGREE: degree_q <= pwdata[DEG_W-1:0];
				REG_POLY:   poly_q   <= pwdata[POLY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DEGREE: prdata = {{(APB_W-DEG_W){1'b0}}, degree_q};
			REG_POLY:   prdata = {{(APB_W-POLY_W){1'b0}}, poly_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.degree      = degree_q;
	assign cfg.poly_coeffs = poly_q;

endmodule

`default_nettype wire

>>> rtl/ssobol_table.sv
// ----------------------------------------------------------------------------
// Direction table
// Initial-number and direction memories with the restart build sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ssobol_table import ssobol_pkg::*; #(
	parameter int MAX_DEGREE = 18
) (
	input  wire             clk,
	input  wire             arst_n,
	input  ssobol_cfg_t     cfg,
	input  ssobol_tbl_req_t req,
	output ssobol_tbl_sts_t sts
);

	localparam int INIT_AW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

	localparam logic [2:0] B_IDLE    = 3'd0;
	localparam logic [2:0] B_ONES    = 3'd1;
	localparam logic [2:0] B_COPY    = 3'd2;
	localparam logic [2:0] B_COPY_WR = 3'd3;
	localparam logic [2:0] B_REC_RD  = 3'd4;
	localparam logic [2:0] B_REC_WR  = 3'd5;

	localparam logic [TBL_AW-1:0] LAST_ADDR = TBL_AW'(TABLE_LEN - 1);

	logic [INIT_W-1:0] init_mem [MAX_DEGREE];
	logic [WORD_W-1:0] dir_mem [TABLE_LEN];
	logic [INIT_W-1:0] init_rdata_q;
	logic [WORD_W-1:0] dir_rdata_q;

	logic [2:0]        bstate_q;
	logic [TBL_AW-1:0] a_q;
	logic [DEG_W-1:0]  k_q;
	logic [DEG_W-1:0]  s_q;
	logic [POLY_W-1:0] poly_q;
	logic [WORD_W-1:0] acc_q;
	logic              copy_s1;
	logic [TBL_AW-1:0] a_s1;
	logic              rec_s1;
	logic [DEG_W-1:0]  k_s1;

	logic [DEG_W-1:0]  s_clamp;
	logic [DEG_W-1:0]  coef_bit;
	logic              coef;
	logic [WORD_W-1:0] acc_next;
	logic              init_re;
	logic              dir_we;
	logic [TBL_AW-1:0] dir_waddr;
	logic [WORD_W-1:0] dir_wdata;
	logic              dir_re;
	logic [TBL_AW-1:0] dir_raddr;

	assign s_clamp = (cfg.degree > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : cfg.degree;

	// coefficient for offset k sits at bit s-1-k; bits past the register read as zero
	assign coef_bit = DEG_W'(s_q - DEG_W'(1) - k_s1);
	assign coef     = (coef_bit < POLY_W) ? poly_q[coef_bit] : 1'b0;
	assign acc_next = (k_s1 == s_q) ? (dir_rdata_q ^ (dir_rdata_q >> s_q))
		: (acc_q ^ (coef ? dir_rdata_q : '0));

	assign init_re = (bstate_q == B_COPY);

	always_comb begin
		dir_we    = 1'b0;
		dir_waddr = a_q;
		dir_wdata = '0;
		if (bstate_q == B_ONES) begin
			dir_we    = 1'b1;
			dir_wdata = {1'b1, {(WORD_W-1){1'b0}}} >> a_q;
		end else if (copy_s1) begin
			dir_we    = 1'b1;
			dir_waddr = a_s1;
			dir_wdata = {{(WORD_W-INIT_W){1'b0}}, init_rdata_q} << (LAST_ADDR - a_s1);
		end else if (bstate_q == B_REC_WR && rec_s1) begin
			dir_we    = 1'b1;
			dir_wdata = acc_next;
		end
	end

	assign dir_re    = (bstate_q == B_REC_RD) || req.rd_en;
	assign dir_raddr = (bstate_q == B_REC_RD) ? TBL_AW'(a_q - k_q) : req.rd_addr;

	always_ff @(posedge clk) begin
		if (req.load_we) begin
			init_mem[req.load_addr[INIT_AW-1:0]] <= req.load_data;
		end
		if (init_re) begin
			init_rdata_q <= init_mem[a_q[INIT_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_waddr] <= dir_wdata;
		end
		if (dir_re) begin
			dir_rdata_q <= dir_mem[dir_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q <= B_IDLE;
			a_q      <= '0;
			k_q      <= '0;
			copy_s1  <= 1'b0;
			rec_s1   <= 1'b0;
		end else begin
			copy_s1 <= 1'b0;
			rec_s1  <= 1'b0;
			unique case (bstate_q)
				B_IDLE: begin
					if (req.build_start) begin
						a_q      <= '0;
						bstate_q <= (s_clamp == '0) ? B_ONES : B_COPY;
					end
				end
				B_ONES: begin
					a_q <= TBL_AW'(a_q + TBL_AW'(1));
					if (a_q == LAST_ADDR) begin
						bstate_q <= B_IDLE;
					end
				end
				B_COPY: begin
					copy_s1 <= 1'b1;
					if (a_q == TBL_AW'(s_q - DEG_W'(1))) begin
						bstate_q <= B_COPY_WR;
					end else begin
						a_q <= TBL_AW'(a_q + TBL_AW'(1));
					end
				end
				B_COPY_WR: begin
					a_q      <= TBL_AW'(s_q);
					k_q      <= s_q;
					bstate_q <= B_REC_RD;
				end
				B_REC_RD: begin
					rec_s1 <= 1'b1;
					if (k_q == DEG_W'(1)) begin
						bstate_q <= B_REC_WR;
					end else begin
						k_q <= DEG_W'(k_q - DEG_W'(1));
					end
				end
				B_REC_WR: begin
					if (a_q == LAST_ADDR) begin
						bstate_q <= B_IDLE;
					end else begin
						a_q      <= TBL_AW'(a_q + TBL_AW'(1));
						k_q      <= s_q;
						bstate_q <= B_REC_RD;
					end
				end
				default: bstate_q <= B_IDLE;
			endcase
		end
	end

	// latch the build parameters and track the read pipeline
	always_ff @(posedge clk) begin
		if (bstate_q == B_IDLE && req.build_start) begin
			s_q    <= s_clamp;
			poly_q <= cfg.poly_coeffs;
		end
		a_s1 <= a_q;
		k_s1 <= k_q;
		if (rec_s1) begin
			acc_q <= acc_next;
		end
	end

	assign sts.busy    = (bstate_q != B_IDLE);
	assign sts.rd_data = dir_rdata_q;

endmodule

`default_nettype wire

>>> rtl/ssobol_scramble.sv
// ----------------------------------------------------------------------------
// Point scrambler
// Multiplies the top 31 bits modulo 2^31-1 and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssobol_scramble import ssobol_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ssobol_push_t        push,
	output logic                push_ready,
	ssobol_out_if.source        results
);

	logic                valid_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic                low_s1;
	logic [WORD_W-1:0]   num_s1;
	logic [STATUS_W-1:0] status_s1;

	logic                out_valid_q;
	logic [WORD_W-1:0]   value_q;
	logic [WORD_W-1:0]   number_q;
	logic [STATUS_W-1:0] status_q;

	logic                out_free;
	logic                s1_go;
	logic [PROD_W-1:0]   prod;
	logic [SCR_BITS:0]   fold;
	logic [SCR_BITS:0]   reduced;

	assign out_free   = !out_valid_q || results.ready;
	assign s1_go      = valid_s1 && out_free;
	assign push_ready = !valid_s1 || out_free;

	assign prod = {{SCR_BITS{1'b0}}, push.raw[WORD_W-1:WORD_W-SCR_BITS]}
		* {{SCR_BITS{1'b0}}, SCR_MULTIPLIER};

	// Mersenne fold: high half plus low half stays below twice the modulus
	assign fold    = {1'b0, prod_s1[PROD_W-1:SCR_BITS]} + {1'b0, prod_s1[SCR_BITS-1:0]};
	assign reduced = (fold >= {1'b0, SCR_MODULUS}) ? (fold - {1'b0, SCR_MODULUS}) : fold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push.valid && push_ready) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid && push_ready) begin
			prod_s1   <= prod;
			low_s1    <= push.raw[0];
			num_s1    <= push.number;
			status_s1 <= push.status;
		end
		if (s1_go) begin
			value_q  <= {reduced[SCR_BITS-1:0], low_s1};
			number_q <= num_s1;
			status_q <= status_s1;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.point_value  = value_q;
	assign results.point_number = number_q;
	assign results.status       = status_q;

endmodule

`default_nettype wire

>>> rtl/scrambled_sobol_point_generator_core.sv
// Next request: the direction memory read is registered and XORed into the running value;
//   the point then passes the scrambler's product and result registers. No new request is
//   taken until the scrambler accepts the point. Load: no result. Restart: table build with
//   single-bit entries at degree 0, else initial numbers then the recurrence; no requests taken meanwhile.
// Reset clears control, table-ready flag, running value and point counter;
//   both memories come up unwritten and get no clearing pass.
`default_nettype none

`include "scrambled_sobol_point_generator_core_defines.svh"

module scrambled_sobol_point_generator_core import ssobol_pkg::*; #(
	parameter int MAX_DEGREE = 18
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire  [PADDR_W-1:0] paddr,
	input  wire  [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready,
	ssobol_in_if.sink          items,
	ssobol_out_if.source       results
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_XOR   = 2'd1;
	localparam logic [1:0] ST_BUILD = 2'd2;

	ssobol_cfg_t     cfg;
	ssobol_tbl_req_t tbl_req;
	ssobol_tbl_sts_t tbl_sts;
	ssobol_push_t    push;
	logic            push_ready;

	logic [1:0]          state_q;
	logic                table_ready_q;
	logic [WORD_W-1:0]   running_q;
	logic [WORD_W:0]     counter_q;
	logic [STATUS_W-1:0] pstat_q;
	logic                first_q;

	logic                accept;
	logic                idx_ok;
	logic [STATUS_W-1:0] next_status;
	logic [TBL_AW-1:0]   point_addr;
	logic [WORD_W-1:0]   lowest_zero;
	logic                point_ok;

	function automatic logic [TBL_AW-1:0] onehot_index(input logic [WORD_W-1:0] oh);
		logic [TBL_AW-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (oh[i]) begin
				idx = idx | TBL_AW'(i);
			end
		end
		return idx;
	endfunction

	ssobol_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssobol_table #(.MAX_DEGREE(MAX_DEGREE)) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (tbl_req),
		.sts    (tbl_sts)
	);

	ssobol_scramble u_scramble (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.results    (results)
	);

	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;

	assign idx_ok = (items.init_index != '0) && (items.init_index <= MAX_DEGREE);

	always_comb begin
		if (!table_ready_q) begin
			next_status = STATUS_NOT_READY;
		end else if (counter_q[WORD_W]) begin
			next_status = STATUS_EXHAUSTED;
		end else begin
			next_status = STATUS_OK;
		end
	end

	// entry picked by the lowest zero of the previous index; all ones picks the last
	assign lowest_zero = ~WORD_W'(counter_q[WORD_W-1:0] - WORD_W'(1)) & counter_q[WORD_W-1:0];
	assign point_addr  = (lowest_zero == '0) ? TBL_AW'(TABLE_LEN - 1)
		: onehot_index(lowest_zero);

	always_comb begin
		tbl_req.build_start = accept && (items.mode == MODE_RESTART);
		tbl_req.load_we     = accept && (items.mode == MODE_LOAD) && idx_ok;
		tbl_req.load_addr   = IDX_W'(items.init_index - IDX_W'(1));
		tbl_req.load_data   = items.init_value;
		tbl_req.rd_en       = accept && (items.mode == MODE_NEXT);
		tbl_req.rd_addr     = point_addr;
	end

	assign point_ok = (pstat_q == STATUS_OK);

	always_comb begin
		push.valid  = (state_q == ST_XOR);
		push.raw    = point_ok ? (running_q ^ (first_q ? '0 : tbl_sts.rd_data)) : '0;
		push.number = point_ok ? counter_q[WORD_W-1:0] : '0;
		push.status = pstat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			table_ready_q <= 1'b0;
			running_q     <= '0;
			counter_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && items.mode == MODE_RESTART) begin
						table_ready_q <= 1'b1;
						running_q     <= '0;
						counter_q     <= '0;
						state_q       <= ST_BUILD;
					end else if (accept && items.mode == MODE_NEXT) begin
						state_q <= ST_XOR;
					end
				end
				ST_XOR: begin
					// hold until the scrambler takes the request
					if (push_ready) begin
						if (point_ok) begin
							running_q <= push.raw;
							counter_q <= (WORD_W+1)'(counter_q + (WORD_W+1)'(1));
						end
						state_q <= ST_IDLE;
					end
				end
				ST_BUILD: begin
					if (!tbl_sts.busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && items.mode == MODE_NEXT) begin
			pstat_q <= next_status;
			first_q <= (counter_q == '0);
		end
	end

	`SSOBOL_ASSERT_IMPLY(a_no_accept_while_building, clk, arst_n, items.valid && items.ready, !tbl_sts.busy, "request accepted during table build")
	`SSOBOL_ASSERT_IMPLY(a_counter_cap, clk, arst_n, counter_q[WORD_W], counter_q[WORD_W-1:0] == '0, "point counter passed its limit")
	`SSOBOL_ASSERT_NEXT(a_read_data_held, clk, arst_n, state_q == ST_XOR && !push_ready, state_q == ST_XOR && $stable(tbl_sts.rd_data), "direction read data lost while stalled")
	`SSOBOL_ASSERT_IMPLY(a_error_payload_zero, clk, arst_n, results.valid && results.status != STATUS_OK, results.point_value == '0 && results.point_number == '0, "error result carries nonzero payload")

endmodule

`default_nettype wire

>>> sim/scrambled_sobol_point_generator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scrambled Sobol point generator testbench
// Drives load, restart and next requests over the request channel, with
// random gaps on both channels and one long result stall. Reprograms the
// degree and coefficient registers between phases. Predicts every point
// from its own copy of the generator state and compares each result field
// by field.
// ----------------------------------------------------------------------------

module scrambled_sobol_point_generator_core_tb;
	import ssobol_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 11;
	localparam int MAX_DEG       = 18;
	localparam int IDLE_PCT      = 27;
	localparam int NUM_PHASES    = 10;
	localparam int PHASE_ITEMS   = 195;
	localparam int SETTLE_CYCLES = 400;
	localparam int HOLD_CYCLES   = 160;
	localparam int HOLD_AT_POINT = 600;
	localparam int STEADY_PHASE  = 6;
	localparam longint TIMEOUT_NS = 5_000_000;

	localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

	typedef struct packed {
		logic [WORD_W-1:0]   value;
		logic [WORD_W-1:0]   number;
		logic [STATUS_W-1:0] status;
	} point_t;

	class sobol_point_scoreboard;
		logic [INIT_W-1:0] init_nums [MAX_DEG];
		logic [WORD_W-1:0] directions [1:TABLE_LEN];
		logic              table_built;
		logic [WORD_W-1:0] raw_value;
		logic [WORD_W:0]   point_count;
		logic [DEG_W-1:0]  degree;
		logic [POLY_W-1:0] poly;
		point_t            expected_points [$];
		int unsigned       failures;
		int unsigned       points_checked;
		int unsigned       loads;
		int unsigned       restarts;
		int unsigned       nexts;
		int unsigned       settings;

		function new();
			foreach (init_nums[i])
				init_nums[i] = '0;
			foreach (directions[i])
				directions[i] = '0;
			table_built = 1'b0;
			raw_value = '0;
			point_count = '0;
			degree = '0;
			poly = '0;
			failures = 0;
			points_checked = 0;
			loads = 0;
			restarts = 0;
			nexts = 0;
			settings = 0;
		endfunction

		function void set_register(logic which, logic [APB_W-1:0] value);
			if (which == REG_DEGREE)
				degree = value[DEG_W-1:0];
			else
				poly = value[POLY_W-1:0];
			settings++;
		endfunction

		function void build_directions();
			int unsigned s;
			logic [WORD_W-1:0] v;
			s = (degree > MAX_DEG) ? MAX_DEG : degree;
			if (s == 0) begin
				for (int i = 1; i <= TABLE_LEN; i++)
					directions[i] = 32'h1 << (32 - i);
				return;
			end
			for (int i = 1; i <= s; i++)
				directions[i] = 32'(init_nums[i-1]) << (32 - i);
			for (int i = s + 1; i <= TABLE_LEN; i++) begin
				v = directions[i-s];
				v ^= v >> s;
				for (int k = 1; k + 1 <= s; k++)
					if (poly[s-1-k])
						v ^= directions[i-k];
				directions[i] = v;
			end
		endfunction

		// keep bit 0, multiply the top 31 bits modulo 2^31 - 1
		function logic [WORD_W-1:0] scramble_point(logic [WORD_W-1:0] raw);
			logic [63:0] prod;
			prod = 64'(SCR_MULTIPLIER) * 64'(raw[WORD_W-1:1]);
			prod = prod % 64'(SCR_MODULUS);
			return {prod[SCR_BITS-1:0], raw[0]};
		endfunction

		function void note_request(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx,
			logic [INIT_W-1:0] val);
			point_t p;
			logic [WORD_W-1:0] prev;
			int unsigned pick;
			case (mode)
				MODE_LOAD: begin
					loads++;
					if (idx >= 1 && idx <= MAX_DEG)
						init_nums[idx-1] = val;
				end
				MODE_RESTART: begin
					restarts++;
					build_directions();
					table_built = 1'b1;
					raw_value = '0;
					point_count = '0;
				end
				MODE_NEXT: begin
					nexts++;
					p = '0;
					if (!table_built)
						p.status = STATUS_NOT_READY;
					else if (point_count[WORD_W])
						p.status = STATUS_EXHAUSTED;
					else begin
						// pick the entry by trailing ones of the previous index
						if (point_count != 0) begin
							prev = point_count[WORD_W-1:0] - 1;
							pick = 1;
							while (prev[0] && pick < TABLE_LEN) begin
								prev >>= 1;
								pick++;
							end
							raw_value ^= directions[pick];
						end
						p.value = scramble_point(raw_value);
						p.number = point_count[WORD_W-1:0];
						p.status = STATUS_OK;
						point_count++;
					end
					expected_points.push_back(p);
				end
				default: ;
			endcase
		endfunction

		function void check_point(logic [WORD_W-1:0] value, logic [WORD_W-1:0] number,
			logic [STATUS_W-1:0] status);
			point_t p;
			points_checked++;
			if (expected_points.size() == 0) begin
				$error("unexpected point: value %h number %0d status %0d",
					value, number, status);
				failures++;
				return;
			end
			p = expected_points.pop_front();
			if (value !== p.value) begin
				$error("point_value: expected %h, actual %h", p.value, value);
				failures++;
			end
			if (number !== p.number) begin
				$error("point_number: expected %0d, actual %0d", p.number, number);
				failures++;
			end
			if (status !== p.status) begin
				$error("status: expected %0d, actual %0d", p.status, status);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return expected_points.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [APB_W-1:0]   pwdata = '0;
	logic [APB_W-1:0]   prdata;
	logic               pready;
	bit                 steady = 1'b0;

	sobol_point_scoreboard sb = new();

	ssobol_in_if  request_bus();
	ssobol_out_if point_bus();

	scrambled_sobol_point_generator_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.items   (request_bus),
		.results (point_bus)
	);

	always #HALF_PERIOD clk = ~clk;

	initial begin
		#TIMEOUT_NS;
		$display("== FAIL ==");
		$finish;
	end

	// result side: check, then pick ready for the next cycle
	initial begin : point_sink
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 1'b0;
		point_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (point_bus.valid === 1'b1 && point_bus.ready === 1'b1)
				sb.check_point(point_bus.point_value, point_bus.point_number,
					point_bus.status);
			if (!held && sb.points_checked >= HOLD_AT_POINT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				point_bus.ready <= 1'b0;
				hold_left--;
			end else
				point_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic send_request(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
		input logic [INIT_W-1:0] val);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			request_bus.valid <= 1'b0;
			@(posedge clk);
		end
		request_bus.valid <= 1'b1;
		request_bus.mode <= mode;
		request_bus.init_index <= idx;
		request_bus.init_value <= val;
		do
			@(posedge clk);
		while (request_bus.ready !== 1'b1);
		sb.note_request(mode, idx, val);
	endtask

	// drop valid, drain results, then let any table build finish
	task automatic wait_idle();
		request_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic which, input logic [APB_W-1:0] value);
		paddr <= {which, 2'b00};
		pwdata <= value;
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_register(which, value);
		@(posedge clk);
	endtask

	initial begin : stimulus
		int                counted;
		int                pick;
		int                k;
		logic [DEG_W-1:0]  deg;
		logic [POLY_W-1:0] coeffs;
		logic [APB_W-1:0]  junk;
		request_bus.valid <= 1'b0;
		request_bus.mode <= MODE_LOAD;
		request_bus.init_index <= '0;
		request_bus.init_value <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: not-ready point, ignored requests, first-dimension table
		send_request(MODE_NEXT, 5'd0, 18'd0);
		send_request(MODE_IGNORED, 5'd31, 18'h3FFFF);
		send_request(MODE_LOAD, 5'd0, 18'h3FFFF);
		send_request(MODE_LOAD, 5'(MAX_DEG + 1), 18'h3FFFF);
		send_request(MODE_LOAD, 5'd31, 18'h00001);
		send_request(MODE_RESTART, 5'd0, 18'd0);
		repeat (4) send_request(MODE_NEXT, 5'd31, 18'h3FFFF);
		// fill every initial number before any restart can read one
		for (k = 1; k <= MAX_DEG; k++)
			send_request(MODE_LOAD, 5'(k), (k % 2) ? 18'd1 : INIT_W'((1 << k) - 1));

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			junk = '0;
			case (ph)
				0: begin deg = 5'd0;  coeffs = 17'h1FFFF; end
				1: begin deg = 5'd1;  coeffs = 17'h1FFFF; end
				2: begin deg = 5'd18; coeffs = 17'h1FFFF; end
				3: begin deg = 5'd31; coeffs = 17'h0AAAA; end
				4: begin deg = 5'd2;  coeffs = 17'h1FFFF; end
				5: begin deg = 5'd18; coeffs = 17'h00000; end
				6: begin deg = 5'd3;  coeffs = 17'h00001; end
				default: begin
					deg = 5'($urandom_range(0, 31));
					coeffs = 17'($urandom);
					junk = $urandom;
				end
			endcase
			write_register(REG_DEGREE, {junk[APB_W-1:DEG_W], deg});
			write_register(REG_POLY, {junk[APB_W-1:POLY_W], coeffs});
			steady = (ph == STEADY_PHASE);
			send_request(MODE_RESTART, 5'($urandom), 18'($urandom));
			counted = 1;
			while (counted < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					send_request(MODE_NEXT, 5'($urandom), 18'($urandom));
					counted++;
				end else if (pick < 84) begin
					// well-formed: odd and below two to the power of its position
					k = $urandom_range(1, MAX_DEG);
					send_request(MODE_LOAD, 5'(k), INIT_W'($urandom_range(0, (1 << k) - 1) | 1));
					counted++;
				end else if (pick < 87) begin
					send_request(MODE_RESTART, 5'($urandom), 18'($urandom));
					counted++;
				end else if (pick < 93) begin
					send_request(MODE_LOAD, 5'($urandom_range(1, MAX_DEG)), 18'($urandom));
					counted++;
				end else if (pick < 97) begin
					k = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_DEG + 1, 31);
					send_request(MODE_LOAD, 5'(k), 18'($urandom));
					counted++;
				end else begin
					send_request(MODE_IGNORED, 5'($urandom), 18'($urandom));
					counted++;
				end
			end
			steady = 1'b0;
		end

		wait_idle();
		$display("Run covered %0d loads, %0d restarts and %0d next requests", sb.loads,
			sb.restarts, sb.nexts);
		$display("over %0d register writes; %0d points checked, %0d mismatches",
			sb.settings, sb.points_checked, sb.failures);
		if (sb.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
